[rtl/core/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// screen geometry, derived widths, character codes, command and result beats
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int TAB_STOP  = 8;

    // derived widths
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_REG_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int COL_REG_W = $clog2(COLUMNS);
    localparam int COL_W     = $clog2(COLUMNS + TAB_STOP);

    // fixed field widths
    localparam int ACT_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 2 * COLOR_W;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int POS_W     = 11;
    localparam int CFG_IDX_W = 1;

    // width of linear address arithmetic, room for a sum below twice the screen
    localparam int WIDE_W    = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    // command queue
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    // actions
    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // blank cell after reset, light grey on black
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef enum logic [1:0] {
        CMD_PLAIN,
        CMD_READ,
        CMD_BLANK,
        CMD_FILL
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_BLANK,
        BK_FILL
    } bk_state_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [POS_W-1:0]     cursor_pos;
        logic                 scrolled;
    } res_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               wr_en;
        logic [ADDR_W-1:0]  addr;
        logic [CELL_W-1:0]  wr_data;
        logic               rd_ok;
        logic [ADDR_W-1:0]  base;
        logic [CELL_W-1:0]  fill_data;
        res_t               res;
    } cmd_t;

endpackage

[rtl/core/tcw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/tcw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front: cursor tracking and command decode
// owns the cursor and the row rotation, turns each input beat into one command
// ----------------------------------------------------------------------------
module tcw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcw_pkg::ACT_W-1:0]      action,
    input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
    input  logic [tcw_pkg::ATTR_W-1:0]     attr,
    input  logic                           init_busy,
    input  logic                           q_full,
    output logic                           q_push,
    output tcw_pkg::cmd_t                  cmd
);

    logic [tcw_pkg::ROW_REG_W-1:0] row_reg, row_next;
    logic [tcw_pkg::COL_REG_W-1:0] col_reg, col_next;
    logic [tcw_pkg::ADDR_W-1:0]    top_reg, top_next;

    logic [tcw_pkg::COL_W-1:0]  col_ext, col_dec, col_step, col_wr, col_new;
    logic [tcw_pkg::ROW_W-1:0]  row_ext, row_step, row_wrap, row_new;
    logic [tcw_pkg::CHAR_W-1:0] wr_char;
    logic                       wr_en;
    logic                       scroll;
    logic [tcw_pkg::WIDE_W-1:0] lin_wr, idx_ext, top_sum, pos_lin;

    // linear cell index to physical address through the row rotation
    function automatic logic [tcw_pkg::ADDR_W-1:0] phys_addr(
        input logic [tcw_pkg::WIDE_W-1:0] lin,
        input logic [tcw_pkg::ADDR_W-1:0] base
    );
        logic [tcw_pkg::WIDE_W-1:0] sum;
        sum = lin + tcw_pkg::WIDE_W'(base);
        if (sum >= tcw_pkg::WIDE_W'(tcw_pkg::CELLS))
        begin
            sum = sum - tcw_pkg::WIDE_W'(tcw_pkg::CELLS);
        end
        return tcw_pkg::ADDR_W'(sum);
    endfunction

    assign in_ready = !q_full && !init_busy;
    assign q_push   = in_valid && in_ready;

    // put character cursor movement
    always_comb
    begin
        col_ext  = tcw_pkg::COL_W'(col_reg);
        row_ext  = tcw_pkg::ROW_W'(row_reg);
        col_dec  = (col_ext != '0) ? col_ext - 1'b1 : col_ext;
        col_step = col_ext;
        row_step = row_ext;
        col_wr   = col_ext;
        wr_en    = 1'b0;
        wr_char  = char_code;
        unique case (char_code)
            tcw_pkg::CH_BS:
            begin
                col_step = col_dec;
                col_wr   = col_dec;
                wr_en    = 1'b1;
                wr_char  = tcw_pkg::CH_SPACE;
            end
            tcw_pkg::CH_TAB:
            begin
                col_step = (col_ext + tcw_pkg::COL_W'(tcw_pkg::TAB_STOP))
                           & ~tcw_pkg::COL_W'(tcw_pkg::TAB_STOP - 1);
            end
            tcw_pkg::CH_LF:
            begin
                row_step = row_ext + 1'b1;
                col_step = '0;
            end
            tcw_pkg::CH_CR:
            begin
                col_step = '0;
            end
            default:
            begin
                wr_en    = 1'b1;
                col_step = col_ext + 1'b1;
            end
        endcase

        // column wrap to the next row
        if (col_step >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
        begin
            col_new  = '0;
            row_wrap = row_step + 1'b1;
        end
        else
        begin
            col_new  = col_step;
            row_wrap = row_step;
        end

        scroll = (row_wrap >= tcw_pkg::ROW_W'(tcw_pkg::ROWS));
    end

    assign lin_wr  = tcw_pkg::WIDE_W'(row_reg) * tcw_pkg::WIDE_W'(tcw_pkg::COLUMNS)
                     + tcw_pkg::WIDE_W'(col_wr);
    assign idx_ext = tcw_pkg::WIDE_W'(cell_index);
    assign top_sum = tcw_pkg::WIDE_W'(top_reg) + tcw_pkg::WIDE_W'(tcw_pkg::COLUMNS);

    // command build and next cursor
    always_comb
    begin
        row_new       = row_ext;
        row_next      = row_reg;
        col_next      = col_reg;
        top_next      = top_reg;
        cmd.kind      = tcw_pkg::CMD_PLAIN;
        cmd.wr_en     = 1'b0;
        cmd.addr      = phys_addr(lin_wr, top_reg);
        cmd.wr_data   = {attr, wr_char};
        cmd.rd_ok     = 1'b0;
        cmd.base      = top_reg;
        cmd.fill_data = {attr, tcw_pkg::CH_SPACE};
        cmd.res.scrolled = 1'b0;
        unique case (action)
            tcw_pkg::ACT_PUT:
            begin
                cmd.wr_en = wr_en;
                row_new   = scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) : row_wrap;
                row_next  = tcw_pkg::ROW_REG_W'(row_new);
                col_next  = tcw_pkg::COL_REG_W'(col_new);
                if (scroll)
                begin
                    // old top row becomes the new bottom row
                    cmd.kind = tcw_pkg::CMD_BLANK;
                    cmd.res.scrolled = 1'b1;
                    if (top_sum >= tcw_pkg::WIDE_W'(tcw_pkg::CELLS))
                    begin
                        top_next = '0;
                    end
                    else
                    begin
                        top_next = tcw_pkg::ADDR_W'(top_sum);
                    end
                end
            end
            tcw_pkg::ACT_CLEAR:
            begin
                cmd.kind      = tcw_pkg::CMD_FILL;
                cmd.fill_data = {attr, char_code};
                row_new       = '0;
                row_next      = '0;
                col_next      = '0;
                top_next      = '0;
            end
            tcw_pkg::ACT_READ:
            begin
                cmd.kind  = tcw_pkg::CMD_READ;
                cmd.addr  = phys_addr(idx_ext, top_reg);
                cmd.rd_ok = (idx_ext < tcw_pkg::WIDE_W'(tcw_pkg::CELLS));
            end
            default:
            begin
                cmd.kind = tcw_pkg::CMD_PLAIN;
            end
        endcase

        pos_lin = tcw_pkg::WIDE_W'(row_next) * tcw_pkg::WIDE_W'(tcw_pkg::COLUMNS)
                  + tcw_pkg::WIDE_W'(col_next);
        cmd.res.cell_data  = '0;
        cmd.res.cursor_row = tcw_pkg::ROW_OUT_W'(row_new);
        cmd.res.cursor_col = tcw_pkg::COL_OUT_W'(col_next);
        cmd.res.cursor_pos = tcw_pkg::POS_W'(pos_lin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            top_reg <= '0;
        end
        else if (q_push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            top_reg <= top_next;
        end
    end

endmodule

[rtl/core/tcw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue: short command queue between decode and execution
// first in first out, head visible while not empty
// ----------------------------------------------------------------------------
module tcw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcw_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output tcw_pkg::cmd_t  head,
    output logic           full,
    output logic           empty
);

    tcw_pkg::cmd_t                entry_reg [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tcw_pkg::Q_PTR_W:0]    count_reg;

    function automatic logic [tcw_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [tcw_pkg::Q_PTR_W-1:0] ptr
    );
        if (ptr == tcw_pkg::Q_PTR_W'(tcw_pkg::Q_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == (tcw_pkg::Q_PTR_W + 1)'(tcw_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/tcw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back: command execution on the screen memory
// cell writes, reads, row blanking and screen fill, plus the result register
// ----------------------------------------------------------------------------
module tcw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tcw_pkg::cmd_t  head,
    input  logic           q_empty,
    output logic           pop,
    output logic           init_busy,
    output logic           out_valid,
    input  logic           out_ready,
    output tcw_pkg::res_t  out_res
);

    tcw_pkg::bk_state_t          state_reg, state_next;
    logic [tcw_pkg::ADDR_W-1:0]  cnt_reg, cnt_next;
    tcw_pkg::cmd_t               cmd_reg;
    logic                        out_valid_reg;
    tcw_pkg::res_t               out_res_reg;

    logic                        out_free;
    logic                        start;
    logic                        finish;
    tcw_pkg::res_t               fin_res;
    logic                        ram_we;
    logic [tcw_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

    assign out_free  = !out_valid_reg || out_ready;
    assign start     = !q_empty && out_free;
    assign init_busy = (state_reg == tcw_pkg::BK_INIT);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::BK_INIT:
            begin
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    state_next = tcw_pkg::BK_IDLE;
                end
            end
            tcw_pkg::BK_IDLE:
            begin
                if (start)
                begin
                    unique case (head.kind)
                        tcw_pkg::CMD_READ:  state_next = tcw_pkg::BK_READ;
                        tcw_pkg::CMD_BLANK: state_next = tcw_pkg::BK_BLANK;
                        tcw_pkg::CMD_FILL:  state_next = tcw_pkg::BK_FILL;
                        default:            state_next = tcw_pkg::BK_IDLE;
                    endcase
                end
            end
            tcw_pkg::BK_READ:
            begin
                state_next = tcw_pkg::BK_IDLE;
            end
            tcw_pkg::BK_BLANK:
            begin
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1))
                begin
                    state_next = tcw_pkg::BK_IDLE;
                end
            end
            tcw_pkg::BK_FILL:
            begin
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    state_next = tcw_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = head.addr;
        ram_wdata = head.wr_data;
        ram_raddr = head.addr;
        finish    = 1'b0;
        fin_res   = cmd_reg.res;
        cnt_next  = cnt_reg + 1'b1;
        unique case (state_reg)
            tcw_pkg::BK_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = tcw_pkg::RESET_CELL;
            end
            tcw_pkg::BK_IDLE:
            begin
                // single cell write or read request goes out with the pop
                pop      = start;
                ram_we   = start && head.wr_en;
                cnt_next = '0;
                finish   = start && (head.kind == tcw_pkg::CMD_PLAIN);
                fin_res  = head.res;
            end
            tcw_pkg::BK_READ:
            begin
                finish = 1'b1;
                fin_res.cell_data = cmd_reg.rd_ok ? ram_rdata : '0;
            end
            tcw_pkg::BK_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = cmd_reg.base + cnt_reg;
                ram_wdata = cmd_reg.fill_data;
                finish    = (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1));
            end
            tcw_pkg::BK_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = cmd_reg.fill_data;
                finish    = (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (finish)
        begin
            out_res_reg <= fin_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::BK_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/text_console_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: 80x25 text console with cursor, scroll and cell read
// decode front end, short command queue, execution back end on a screen ram
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | action, char_code, cell_index
//  out      | out_valid / out_ready| cell_data, cursor_row, cursor_col,
//           |                      | cursor_pos, scrolled
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  back end: put and no-op finish in the idle state, a read passes idle and the read
//    state; a put that scrolls blanks COLUMNS cells, a clear all ROWS*COLUMNS, both
//    through the single write port of the screen ram (one cell a cycle)
//  reset: a clearing pass writes the blank cell to all ROWS*COLUMNS cells,
//    in_ready stays low until it ends
//  stalls: a four entry command queue lets the front accept beats while the
//    back end blanks or fills, and the result register holds a beat while
//    out_ready is low
//
module text_console_writer (
    input  logic                              clk,
    input  logic                              rst_n,

    // input beats
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tcw_pkg::ACT_W-1:0]         action,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::IDX_W-1:0]         cell_index,

    // result beats
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tcw_pkg::CELL_W-1:0]        cell_data,
    output logic [tcw_pkg::ROW_OUT_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]     cursor_col,
    output logic [tcw_pkg::POS_W-1:0]         cursor_pos,
    output logic                              scrolled,

    // configuration writes
    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data
);

    // color registers, applied when a cell is written
    logic [tcw_pkg::COLOR_W-1:0] fg_reg;
    logic [tcw_pkg::COLOR_W-1:0] bg_reg;
    logic [tcw_pkg::ATTR_W-1:0]  attr;

    // front to queue
    logic           q_push;
    logic           q_full;
    tcw_pkg::cmd_t  push_cmd;

    // queue to back
    logic           q_pop;
    logic           q_empty;
    tcw_pkg::cmd_t  head;

    // back status
    logic           init_busy;
    tcw_pkg::res_t  out_res;

    assign attr = {bg_reg, fg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tcw_pkg::FG_RESET;
            bg_reg <= tcw_pkg::BG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcw_pkg::CFG_FG: fg_reg <= cfg_data;
                tcw_pkg::CFG_BG: bg_reg <= cfg_data;
                default:         fg_reg <= fg_reg;
            endcase
        end
    end

    // front: cursor update and command decode, one beat a cycle while the queue has room and the clearing pass is over
    tcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .char_code  (char_code),
        .cell_index (cell_index),
        .attr       (attr),
        .init_busy  (init_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .cmd        (push_cmd)
    );

    // command queue decouples decode from the screen ram work
    tcw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: screen ram sequencing and result register
    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign cell_data  = out_res.cell_data;
    assign cursor_row = out_res.cursor_row;
    assign cursor_col = out_res.cursor_col;
    assign cursor_pos = out_res.cursor_pos;
    assign scrolled   = out_res.scrolled;

    // no beat taken while the clearing pass runs
    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !in_ready)
        else $error("input accepted during clearing pass");

    // queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    // reported cursor stays on screen
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_col < tcw_pkg::COLUMNS) && (cursor_row < tcw_pkg::ROWS))
        else $error("cursor off screen");

endmodule

[sim/tcw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker: shadow console and result comparison for the text console writer
// tracks every accepted command and color write, predicts the cursor report of
// each command and compares it with the result beats in order
// ----------------------------------------------------------------------------
module tcw_checker (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [tcw_pkg::ACT_W-1:0]         action,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::IDX_W-1:0]         cell_index,

    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [tcw_pkg::CELL_W-1:0]        cell_data,
    input  logic [tcw_pkg::ROW_OUT_W-1:0]     cursor_row,
    input  logic [tcw_pkg::COL_OUT_W-1:0]     cursor_col,
    input  logic [tcw_pkg::POS_W-1:0]         cursor_pos,
    input  logic                              scrolled,

    input  logic                              cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data,

    output int                                errors,
    output int                                pending
);
    import tcw_pkg::*;

    logic [CELL_W-1:0]  screen_shadow [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] fg_shadow;
    logic [COLOR_W-1:0] bg_shadow;
    res_t               cursor_reports [$];
    res_t               oldest;

    // applies one command to the shadow console and returns its report
    function automatic res_t apply_console_op(input logic [ACT_W-1:0]  act,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [IDX_W-1:0]  idx);
        res_t              rep;
        logic [ATTR_W-1:0] attr;
        int                k;
        rep  = '0;
        attr = {bg_shadow, fg_shadow};
        case (act)
            ACT_PUT:
            begin
                case (ch)
                    CH_BS:
                    begin
                        if (cur_col > 0)
                            cur_col--;
                        screen_shadow[cur_row * COLUMNS + cur_col] = {attr, CH_SPACE};
                    end
                    CH_TAB: cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                    CH_LF:
                    begin
                        cur_row++;
                        cur_col = 0;
                    end
                    CH_CR: cur_col = 0;
                    default:
                    begin
                        screen_shadow[cur_row * COLUMNS + cur_col] = {attr, ch};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    for (k = 0; k < CELLS - COLUMNS; k++)
                        screen_shadow[k] = screen_shadow[k + COLUMNS];
                    for (k = CELLS - COLUMNS; k < CELLS; k++)
                        screen_shadow[k] = {attr, CH_SPACE};
                    cur_row      = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                for (k = 0; k < CELLS; k++)
                    screen_shadow[k] = {attr, ch};
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ:
            begin
                if (idx < CELLS)
                    rep.cell_data = screen_shadow[idx];
            end
            default: ;
        endcase
        rep.cursor_row = ROW_OUT_W'(cur_row);
        rep.cursor_col = COL_OUT_W'(cur_col);
        rep.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
        return rep;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CELLS; k++)
                screen_shadow[k] = RESET_CELL;
            cur_row   = 0;
            cur_col   = 0;
            fg_shadow = FG_RESET;
            bg_shadow = BG_RESET;
            cursor_reports.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                cursor_reports.push_back(apply_console_op(action, char_code, cell_index));
            if (out_valid && out_ready)
            begin
                if (cursor_reports.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    errors++;
                end
                else
                begin
                    oldest = cursor_reports.pop_front();
                    if (cell_data !== oldest.cell_data)
                    begin
                        $error("cell_data expected %h got %h", oldest.cell_data, cell_data);
                        errors++;
                    end
                    if (cursor_row !== oldest.cursor_row)
                    begin
                        $error("cursor_row expected %0d got %0d", oldest.cursor_row,
                               cursor_row);
                        errors++;
                    end
                    if (cursor_col !== oldest.cursor_col)
                    begin
                        $error("cursor_col expected %0d got %0d", oldest.cursor_col,
                               cursor_col);
                        errors++;
                    end
                    if (cursor_pos !== oldest.cursor_pos)
                    begin
                        $error("cursor_pos expected %0d got %0d", oldest.cursor_pos,
                               cursor_pos);
                        errors++;
                    end
                    if (scrolled !== oldest.scrolled)
                    begin
                        $error("scrolled expected %0d got %0d", oldest.scrolled, scrolled);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FG: fg_shadow = cfg_data;
                    CFG_BG: bg_shadow = cfg_data;
                    default: ;
                endcase
            end
            pending = cursor_reports.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the text console writer
// directed commands hit reads at the screen edges, out-of-range reads, the
// unused action, every control character and clears; random lines of text with
// control characters then drive wraps and scrolls under three idling phases and
// a range of color settings, while the checker compares every result beat
// ----------------------------------------------------------------------------
module testbench;
    import tcw_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_ITEMS     = 1600;
    localparam int PHASES           = 3;
    localparam int BLOCKS_PER_PHASE = 4;
    localparam int HOLD_OFF_CYCLES  = 400;
    // a clear keeps the ram busy for a full screen, let it finish before recoloring
    localparam int CLEAR_SETTLE     = CELLS + 200;
    localparam int TAIL_CYCLES      = 100;
    // longest legal quiet stretch is the reset clearing pass or a recolor pause
    localparam int STALL_LIMIT      = 20000;

    // action code the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;

    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [ACT_W-1:0]      action     = ACT_PUT;
    logic [CHAR_W-1:0]     char_code  = '0;
    logic [IDX_W-1:0]      cell_index = '0;

    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [CELL_W-1:0]     cell_data;
    logic [ROW_OUT_W-1:0]  cursor_row;
    logic [COL_OUT_W-1:0]  cursor_col;
    logic [POS_W-1:0]      cursor_pos;
    logic                  scrolled;

    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_FG;
    logic [COLOR_W-1:0]    cfg_data   = '0;

    int                    errors;
    int                    pending;

    // idling percentages of both sides, set per phase
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    items_sent    = 0;
    int                    quiet_cycles  = 0;
    logic                  hold_off_req  = 1'b0;
    logic                  hold_off_done = 1'b0;

    // color plan for the first blocks covers the extremes of both registers
    logic [COLOR_W-1:0]    fg_plan [4] = '{4'hF, 4'h0, 4'hF, 4'h0};
    logic [COLOR_W-1:0]    bg_plan [4] = '{4'h0, 4'hF, 4'hF, 4'h0};

    always #(HALF_PERIOD) clk = ~clk;

    text_console_writer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cursor_pos (cursor_pos),
        .scrolled   (scrolled),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tcw_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cursor_pos (cursor_pos),
        .scrolled   (scrolled),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                // receiver goes deaf so the command queue fills and in_ready drops
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: any cycle without a beat on either channel counts as quiet
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // offers one command beat and returns at the edge that accepts it
    task automatic send_beat(input logic [ACT_W-1:0]  act,
                             input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0]  idx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        action     <= act;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // stops sending, waits for every result and any trailing fill, then sets colors
    task automatic drain_and_recolor(input logic [COLOR_W-1:0] fg,
                                     input logic [COLOR_W-1:0] bg);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (CLEAR_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FG;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= CFG_BG;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one line of text with some control characters, its line end and a bit of noise
    task automatic send_text_line();
        int                len;
        int                k;
        int                pick;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        // half the lines are short so the cursor reaches the bottom row often
        len = $urandom_range(1) ? $urandom_range(0, 12) : $urandom_range(0, 100);
        for (k = 0; k < len; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                ch = CH_BS;
            else if (pick < 9)
                ch = CH_TAB;
            else if (pick < 11)
                ch = CH_CR;
            else if (pick < 16)
                ch = 8'($urandom_range(255));
            else
                ch = 8'($urandom_range(8'h20, 8'h7E));
            send_beat(ACT_PUT, ch, 11'($urandom_range(2047)));
        end
        pick = $urandom_range(99);
        if (pick < 70)
            send_beat(ACT_PUT, CH_LF, 11'($urandom_range(2047)));
        else if (pick < 85)
        begin
            send_beat(ACT_PUT, CH_CR, 11'($urandom_range(2047)));
            send_beat(ACT_PUT, CH_LF, 11'($urandom_range(2047)));
        end
        // otherwise the line runs on into the next one

        pick = $urandom_range(99);
        if (pick < 15)
            idx = 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
        else if (pick < 27)
            idx = 11'($urandom_range(0, CELLS - 1));
        else
            idx = 11'($urandom_range(CELLS, 2047));
        pick = $urandom_range(99);
        if (pick < 35)
            send_beat(ACT_READ, 8'($urandom_range(255)), idx);
        else if (pick < 39)
            send_beat(ACT_UNUSED, 8'($urandom_range(255)), 11'($urandom_range(2047)));
        else if (pick < 41)
            send_beat(ACT_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
    endtask

    initial
    begin
        int phase_no;
        int blk;
        int goal;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: screen edges, out of range reads, unused action
        send_beat(ACT_READ,   8'h00, 11'd0);
        send_beat(ACT_READ,   8'h00, 11'd1999);
        send_beat(ACT_READ,   8'h00, 11'd2000);
        send_beat(ACT_READ,   8'hFF, 11'h7FF);
        send_beat(ACT_UNUSED, 8'hFF, 11'h7FF);
        // printable extremes, then each control character
        send_beat(ACT_PUT,    8'h41, 11'd0);
        send_beat(ACT_PUT,    8'h00, 11'd0);
        send_beat(ACT_PUT,    8'hFF, 11'd0);
        send_beat(ACT_PUT,    CH_BS, 11'd0);
        send_beat(ACT_PUT,    CH_CR, 11'd0);
        // backspace at column zero stays put and blanks the cell
        send_beat(ACT_PUT,    CH_BS, 11'd0);
        send_beat(ACT_PUT,    CH_TAB, 11'd0);
        send_beat(ACT_PUT,    CH_TAB, 11'd0);
        send_beat(ACT_PUT,    CH_LF, 11'd0);
        send_beat(ACT_READ,   8'h00, 11'd0);
        send_beat(ACT_READ,   8'h00, 11'd1);
        send_beat(ACT_READ,   8'h00, 11'd2);
        // clears with both extremes of the fill character
        send_beat(ACT_CLEAR,  8'hFF, 11'd0);
        send_beat(ACT_READ,   8'h00, 11'd1999);
        send_beat(ACT_CLEAR,  8'h00, 11'h7FF);
        send_beat(ACT_PUT,    CH_SPACE, 11'd0);
        send_beat(ACT_READ,   8'h00, 11'd0);
        send_beat(ACT_READ,   8'h00, 11'd79);

        // random lines: receiver idles more, then sender idles more, then neither
        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            send_idle_pct = (phase_no == 0) ? 36 : (phase_no == 1) ? 63 : 0;
            recv_idle_pct = (phase_no == 0) ? 63 : (phase_no == 1) ? 36 : 0;
            for (blk = 0; blk < BLOCKS_PER_PHASE; blk++)
            begin
                if (phase_no * BLOCKS_PER_PHASE + blk < 4)
                    drain_and_recolor(fg_plan[phase_no * BLOCKS_PER_PHASE + blk],
                                      bg_plan[phase_no * BLOCKS_PER_PHASE + blk]);
                else
                    drain_and_recolor(4'($urandom_range(15)), 4'($urandom_range(15)));
                // full-speed phase: receiver stalls a long time while lines keep coming
                if (phase_no == PHASES - 1 && blk == 1)
                    hold_off_req = 1'b1;
                goal = items_sent + RANDOM_ITEMS / (PHASES * BLOCKS_PER_PHASE);
                while (items_sent < goal)
                    send_text_line();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[text_console_writer.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
sim/tcw_checker.sv
sim/testbench.sv
